@@ src/spherical_to_cartesian_macros.svh @@
// Assertion helpers used by spherical_to_cartesian.sv.
`ifndef SPHERICAL_TO_CARTESIAN_MACROS_SVH
`define SPHERICAL_TO_CARTESIAN_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define S2C_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define S2C_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/s2c_pkg.sv @@
`default_nettype none
package s2c_pkg;

    typedef logic signed [63:0] t_q60;

    localparam int MUL_LAT  = 5;
    localparam int WRAP_LAT = 4;

    localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
    localparam logic [63:0] DEG2RAD_Q69 = ((PI_Q60 / 64'd180) << 9)
                                        + (((PI_Q60 % 64'd180) << 9) / 64'd180);
    localparam t_q60        GAIN_Q60    = 64'sd700114967507363238;
    localparam logic [32:0] RADIUS_RESET = 33'd6378137000;

    localparam t_q60 OUT_MAX = 64'sd8589934591;
    localparam t_q60 OUT_MIN = -64'sd8589934592;

    // floor(2^e / d) by long division, used only on constants.
    function automatic logic [63:0] pow2_div(input int e, input logic [63:0] d);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], (b == e)};
            if (rem >= d) begin
                rem    = rem - d;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Arctangent of 2^-i in Q60: pi/4 for i = 0, else from the truncated odd-power series.
    function automatic t_q60 atan_entry(input int i);
        t_q60 s;
        int   e;
        s = '0;
        if (i == 0) begin
            s = t_q60'(PI_Q60 >> 2);
        end else begin
            for (int k = 0; k < 64; k++) begin
                e = 60 - i * (2 * k + 1);
                if (e >= 0) begin
                    if (k[0]) s = s - t_q60'(pow2_div(e, 64'(2 * k + 1)));
                    else      s = s + t_q60'(pow2_div(e, 64'(2 * k + 1)));
                end
            end
        end
        return s;
    endfunction

    function automatic logic [33:0] sat34(input t_q60 v);
        t_q60 c;
        c = v;
        if (c > OUT_MAX) c = OUT_MAX;
        if (c < OUT_MIN) c = OUT_MIN;
        return c[33:0];
    endfunction

endpackage
`default_nettype wire

@@ src/spherical_to_cartesian.sv @@
// The unrolled CORDIC stages and the 5-stage multipliers make up the pipeline from an accepted
// transaction to its result.
// Throughput: one transaction per cycle; the whole pipeline holds while the output is stalled.
// Reset (synchronous, active low) empties the pipeline and sets earth_radius to 6378137000 mm.
`default_nettype none
module spherical_to_cartesian #(
    parameter int ANGLE_FRAC_BITS = 20,
    parameter int TRIG_ITERATIONS = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [32:0]  i_cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // longitude [28:0], latitude [56:29], height [84:57], zero fill
    input  wire logic [87:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // pos_x [33:0], pos_y [67:34], pos_z [101:68], zero fill
    output logic      [103:0] m_axis_tdata
);
    import s2c_pkg::*;

    `include "spherical_to_cartesian_macros.svh"

    localparam int TRIG_LAT = TRIG_ITERATIONS + WRAP_LAT + 2 * MUL_LAT + 1;
    localparam int LAT      = TRIG_LAT + 2 * MUL_LAT + 1;

    logic [32:0]    r_earth_radius;
    logic [LAT-1:0] r_vld;
    logic           w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_earth_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_earth_radius <= i_cfg_wdata;
        end
    end

    assign w_en          = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    t_q60 w_cos_lat, w_sin_lat, w_cos_lon, w_sin_lon;

    s2c_trig #(.AW(28), .FRAC(ANGLE_FRAC_BITS), .ITER(TRIG_ITERATIONS)) u_lat (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (s_axis_tdata[56:29]),
        .o_cos   (w_cos_lat),
        .o_sin   (w_sin_lat)
    );

    s2c_trig #(.AW(29), .FRAC(ANGLE_FRAC_BITS), .ITER(TRIG_ITERATIONS)) u_lon (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (s_axis_tdata[28:0]),
        .o_cos   (w_cos_lon),
        .o_sin   (w_sin_lon)
    );

    t_q60        r_rd  [0:TRIG_LAT-1];
    t_q60        r_cod [0:MUL_LAT-1];
    t_q60        r_sod [0:MUL_LAT-1];
    t_q60        r_zd  [0:MUL_LAT-1];
    logic [63:0] w_q, w_z, w_x, w_y;
    logic [103:0] r_out;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rd[0] <= t_q60'({31'd0, r_earth_radius})
                     + {{36{s_axis_tdata[84]}}, s_axis_tdata[84:57]};
            for (int k = 1; k < TRIG_LAT; k++) r_rd[k] <= r_rd[k-1];
            r_cod[0] <= w_cos_lon;
            r_sod[0] <= w_sin_lon;
            r_zd[0]  <= signed'(w_z);
            for (int k = 1; k < MUL_LAT; k++) begin
                r_cod[k] <= r_cod[k-1];
                r_sod[k] <= r_sod[k-1];
                r_zd[k]  <= r_zd[k-1];
            end
            r_out <= {2'b00, sat34(r_zd[MUL_LAT-1]), sat34(signed'(w_y)),
                      sat34(signed'(w_x))};
        end
    end

    // q is the equatorial length in Q28 millimetres.
    s2c_mul #(.SH(32), .SIGNED_B(1'b1)) u_q (
        .i_clk (i_clk), .i_en (w_en),
        .i_a (r_rd[TRIG_LAT-1]), .i_b (w_cos_lat), .o_p (w_q)
    );

    s2c_mul #(.SH(60), .SIGNED_B(1'b1)) u_z (
        .i_clk (i_clk), .i_en (w_en),
        .i_a (r_rd[TRIG_LAT-1]), .i_b (w_sin_lat), .o_p (w_z)
    );

    s2c_mul #(.SH(88), .SIGNED_B(1'b1)) u_x (
        .i_clk (i_clk), .i_en (w_en),
        .i_a (w_q), .i_b (r_cod[MUL_LAT-1]), .o_p (w_x)
    );

    s2c_mul #(.SH(88), .SIGNED_B(1'b1)) u_y (
        .i_clk (i_clk), .i_en (w_en),
        .i_a (w_q), .i_b (r_sod[MUL_LAT-1]), .o_p (w_y)
    );

    assign m_axis_tdata = r_out;

    `S2C_ASSERT_NEXT(a_stall_keeps_items, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready, $stable(r_vld), "items moved during a stall")
    `S2C_ASSERT_NEXT(a_empty_stays_empty, i_clk, i_rst_n,
        (r_vld == '0) && !s_axis_tvalid, r_vld == '0, "pipeline filled without a transaction")
    `S2C_ASSERT_NOW(a_result_from_pipe, i_clk, i_rst_n,
        $rose(m_axis_tvalid), $past(r_vld[LAT-2]), "result without a preceding stage")
endmodule
`default_nettype wire

@@ src/s2c_mul.sv @@
`default_nettype none
module s2c_mul #(
    parameter int SH       = 60,
    parameter bit SIGNED_B = 1'b1
) (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic      [63:0] o_p
);
    // Sign-magnitude product, rounded half away from zero at bit SH.
    localparam logic [127:0] RND = 128'd1 << (SH - 1);

    logic [63:0]  r_ua, r_ub;
    logic [63:0]  r_p00, r_p01, r_p10, r_p11;
    logic [127:0] r_sum;
    logic [62:0]  r_mag;
    logic [63:0]  r_p;
    logic [3:0]   r_neg;
    logic [127:0] n_sh;

    assign n_sh = (r_sum + RND) >> SH;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ua  <= i_a[63] ? (64'd0 - i_a) : i_a;
            r_ub  <= (SIGNED_B && i_b[63]) ? (64'd0 - i_b) : i_b;
            r_neg <= {r_neg[2:0], i_a[63] ^ (SIGNED_B & i_b[63])};
            r_p00 <= 64'(r_ua[31:0])  * 64'(r_ub[31:0]);
            r_p01 <= 64'(r_ua[31:0])  * 64'(r_ub[63:32]);
            r_p10 <= 64'(r_ua[63:32]) * 64'(r_ub[31:0]);
            r_p11 <= 64'(r_ua[63:32]) * 64'(r_ub[63:32]);
            r_sum <= {64'd0, r_p00} + {32'd0, r_p01, 32'd0}
                   + {32'd0, r_p10, 32'd0} + {r_p11, 64'd0};
            r_mag <= n_sh[62:0];
            r_p   <= r_neg[3] ? (64'd0 - {1'b0, r_mag}) : {1'b0, r_mag};
        end
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

@@ src/s2c_trig.sv @@
`default_nettype none
module s2c_trig #(
    parameter int AW   = 29,
    parameter int FRAC = 20,
    parameter int ITER = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [AW-1:0] i_angle,
    output logic signed [63:0] o_cos,
    output logic signed [63:0] o_sin
);
    import s2c_pkg::*;

    localparam logic [63:0] FULL    = 64'd360 << FRAC;
    localparam logic [63:0] HALF    = 64'd180 << FRAC;
    localparam logic [63:0] QUARTER = 64'd90 << FRAC;
    // Offset that makes the angle nonnegative; a whole number of turns.
    localparam logic [63:0] OFF  = (((64'd1 << (AW - 1)) + FULL - 64'd1) / FULL) * FULL;
    localparam logic [63:0] UMAX = (64'd1 << AW) + 64'd2 * FULL;
    localparam int          UW   = $clog2(UMAX);
    localparam logic [63:0] RECIP = (64'd1 << UW) / FULL;
    localparam int          RW   = $clog2(RECIP + 64'd1);
    localparam int          AFW  = UW + 1;
    localparam int          NDL  = 2 * MUL_LAT + ITER;

    localparam logic [UW-1:0]         FULL_U    = FULL[UW-1:0];
    localparam logic [RW-1:0]         RECIP_R   = RECIP[RW-1:0];
    localparam logic signed [AFW-1:0] HALF_S    = AFW'(HALF);
    localparam logic signed [AFW-1:0] QUARTER_S = AFW'(QUARTER);

    logic [63:0]          n_ext;
    logic [UW-1:0]        r_u, r_u2, r_m, n_m2;
    logic [UW+RW-1:0]     r_prod;
    logic [RW-1:0]        n_q;
    logic signed [AFW-1:0] n_a2, r_af;
    logic                 r_neg;
    logic [NDL-1:0]       r_neg_d;
    logic [63:0]          w_rad;

    assign n_ext = {{(64 - AW){i_angle[AW-1]}}, i_angle};
    assign n_q   = r_prod[UW+RW-1:UW];
    assign n_m2  = (r_m >= FULL_U) ? (r_m - FULL_U) : r_m;
    assign n_a2  = signed'({1'b0, n_m2}) - HALF_S;

    // Wrap into one turn, then fold into -90..90 degrees.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u    <= UW'(n_ext + HALF + OFF);
            r_u2   <= r_u;
            r_prod <= (UW + RW)'(r_u) * (UW + RW)'(RECIP_R);
            r_m    <= r_u2 - (UW'(n_q) * FULL_U);
            if (n_a2 > QUARTER_S) begin
                r_af  <= n_a2 - HALF_S;
                r_neg <= 1'b1;
            end else if (n_a2 < -QUARTER_S) begin
                r_af  <= n_a2 + HALF_S;
                r_neg <= 1'b1;
            end else begin
                r_af  <= n_a2;
                r_neg <= 1'b0;
            end
            r_neg_d <= {r_neg_d[NDL-2:0], r_neg};
        end
    end

    s2c_mul #(.SH(9 + FRAC), .SIGNED_B(1'b0)) u_rad (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   ({{(64 - AFW){r_af[AFW-1]}}, r_af}),
        .i_b   (DEG2RAD_Q69),
        .o_p   (w_rad)
    );

    t_q60 r_cx [1:ITER];
    t_q60 r_cy [1:ITER];
    t_q60 r_cz [1:ITER];

    for (genvar gi = 0; gi < ITER; gi++) begin : g_cordic
        localparam t_q60 ATAN = atan_entry(gi);
        t_q60 x_in, y_in, z_in;
        if (gi == 0) begin : g_first
            assign x_in = GAIN_Q60;
            assign y_in = '0;
            assign z_in = signed'(w_rad);
        end else begin : g_next
            assign x_in = r_cx[gi];
            assign y_in = r_cy[gi];
            assign z_in = r_cz[gi];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!z_in[63]) begin
                    r_cx[gi+1] <= x_in - (y_in >>> gi);
                    r_cy[gi+1] <= y_in + (x_in >>> gi);
                    r_cz[gi+1] <= z_in - ATAN;
                end else begin
                    r_cx[gi+1] <= x_in + (y_in >>> gi);
                    r_cy[gi+1] <= y_in - (x_in >>> gi);
                    r_cz[gi+1] <= z_in + ATAN;
                end
            end
        end
    end

    // First-order rotation by the residual angle.
    logic [63:0] w_pyz, w_pxz;
    t_q60        r_xd [0:MUL_LAT-1];
    t_q60        r_yd [0:MUL_LAT-1];
    t_q60        n_nx, n_ny;
    t_q60        r_cos, r_sin;

    s2c_mul #(.SH(60), .SIGNED_B(1'b1)) u_yz (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (r_cy[ITER]),
        .i_b   (r_cz[ITER]),
        .o_p   (w_pyz)
    );

    s2c_mul #(.SH(60), .SIGNED_B(1'b1)) u_xz (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (r_cx[ITER]),
        .i_b   (r_cz[ITER]),
        .o_p   (w_pxz)
    );

    assign n_nx = r_xd[MUL_LAT-1] - signed'(w_pyz);
    assign n_ny = r_yd[MUL_LAT-1] + signed'(w_pxz);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xd[0] <= r_cx[ITER];
            r_yd[0] <= r_cy[ITER];
            for (int k = 1; k < MUL_LAT; k++) begin
                r_xd[k] <= r_xd[k-1];
                r_yd[k] <= r_yd[k-1];
            end
            r_cos <= r_neg_d[NDL-1] ? -n_nx : n_nx;
            r_sin <= r_neg_d[NDL-1] ? -n_ny : n_ny;
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;
endmodule
`default_nettype wire
